// ===== rtl/ccbb_pkg.sv =====
// ----------------------------------------------------------------------------
// Character class bitmap builder package
// Beat types, parse phases and character constants shared by the builder.
// ----------------------------------------------------------------------------
package ccbb_pkg;

  localparam int unsigned SetBits   = 256;
  localparam int unsigned WordBits  = 64;
  localparam int unsigned WordCount = SetBits / WordBits;
  localparam int unsigned WordIdxW  = $clog2(WordCount);

  localparam logic [7:0] CaretCode     = 8'h5E;  // '^'
  localparam logic [7:0] DashCode      = 8'h2D;  // '-'
  localparam logic [7:0] BackslashCode = 8'h5C;  // backslash

  // Input beat: one byte of the class text.
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
    logic       is_empty;
  } ccbb_in_t;

  // Output beat: one 64-bit slice of the finished set.
  typedef struct packed {
    logic [WordIdxW-1:0] word_index;
    logic [WordBits-1:0] word_value;
    logic                last_word;
  } ccbb_out_t;

  // Parse phase of the class text.
  typedef enum logic [1:0] {
    PhStart = 2'd0,
    PhIn    = 2'd1,
    PhRange = 2'd2,
    PhEsc   = 2'd3
  } ccbb_phase_e;

  // Maps the letter after a backslash to its control code.
  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h61:   r = 8'd7;   // a
      8'h62:   r = 8'd8;   // b
      8'h65:   r = 8'd27;  // e
      8'h66:   r = 8'd12;  // f
      8'h6E:   r = 8'd10;  // n
      8'h72:   r = 8'd13;  // r
      8'h74:   r = 8'd9;   // t
      8'h76:   r = 8'd11;  // v
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/char_class_bitmap_builder.sv =====
// ----------------------------------------------------------------------------
// Character class bitmap builder
// Builds the 256-bit membership set of a bracket expression from its text.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one byte of the class text per beat. A beat
//   with is_last high ends the class; a beat with is_empty high ends an
//   empty class (all zeros) and drops any class in progress.
//   Each byte is folded into the working set in the cycle it is accepted,
//   so one byte is taken every cycle while no ending byte waits for the
//   buffer. The range fill is a parallel compare of all 256 codes against
//   the range bounds. When a class ends, the set is copied into an output
//   buffer and sent as four 64-bit beats, lowest codes first, last_word
//   high on the fourth. The first word appears in the cycle after the
//   ending byte is accepted. The next class may be fed while the buffer
//   drains; only a second ending byte waits until the fourth word of the
//   previous set is taken.
//   When the receiver stalls, the current word holds and the buffer stays
//   full. Reset empties the buffer and returns the parser to the start of
//   a class with an empty set.
// ----------------------------------------------------------------------------
module char_class_bitmap_builder
  import ccbb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ccbb_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ccbb_out_t out_data_o
);

  // Working state of the parser.
  logic [SetBits-1:0]  set_q, set_d;
  logic [7:0]          prev_q, prev_d;
  logic                prev_vld_q, prev_vld_d;
  logic                neg_q, neg_d;
  ccbb_phase_e         phase_q, phase_d;

  // Output buffer.
  logic [SetBits-1:0]  snap_q, snap_d;
  logic [WordIdxW-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;

  logic                in_fire, out_fire, finish, drain_done;
  logic [7:0]          c;
  logic                start_caret;
  ccbb_phase_e         ph_eff;
  logic                do_mark;
  logic [SetBits-1:0]  base_set, mask;
  logic [7:0]          mark_code;

  assign c       = in_data_i.char_code;
  assign finish  = in_data_i.is_last | in_data_i.is_empty;
  assign out_fire   = out_valid_o & out_ready_i;
  assign drain_done = out_fire & (cnt_q == WordIdxW'(WordCount - 1));

  // An ending byte waits until the buffer is free or frees this cycle.
  assign in_ready_o = !busy_q || !(in_valid_i && finish) || drain_done;
  assign in_fire    = in_valid_i & in_ready_o;

  // A class start is handled as the inside phase for its first byte.
  assign start_caret = (phase_q == PhStart) && (c == CaretCode);
  assign ph_eff      = (phase_q == PhStart) ? PhIn : phase_q;

  // Next phase, previous code and polarity.
  always_comb begin
    phase_d    = phase_q;
    prev_d     = prev_q;
    prev_vld_d = prev_vld_q;
    neg_d      = neg_q;
    if (in_fire) begin
      if (in_data_i.is_empty) begin
        phase_d    = PhStart;
        prev_d     = 8'd0;
        prev_vld_d = 1'b0;
        neg_d      = 1'b0;
      end else begin
        if (phase_q == PhStart) begin
          neg_d      = start_caret;
          prev_vld_d = 1'b0;
        end
        if (start_caret) begin
          phase_d = PhIn;
        end else begin
          case (ph_eff)
            PhRange: begin
              prev_vld_d = 1'b0;
              phase_d    = PhIn;
            end
            PhEsc: begin
              prev_d     = unescape(c);
              prev_vld_d = 1'b1;
              phase_d    = PhIn;
            end
            default: begin
              if (c == DashCode && !in_data_i.is_last &&
                  (prev_vld_q && phase_q != PhStart)) begin
                phase_d = PhRange;
              end else if (c == BackslashCode && !in_data_i.is_last) begin
                phase_d = PhEsc;
              end else begin
                prev_d     = c;
                prev_vld_d = 1'b1;
                phase_d    = PhIn;
              end
            end
          endcase
        end
        // Ending the class returns everything to the start.
        if (in_data_i.is_last) begin
          phase_d    = PhStart;
          prev_d     = 8'd0;
          prev_vld_d = 1'b0;
          neg_d      = 1'b0;
        end
      end
    end
  end

  // Member mask for this byte: a range, an escaped code or a single code.
  always_comb begin
    mark_code = (ph_eff == PhEsc) ? unescape(c) : c;
    do_mark   = 1'b0;
    mask      = '0;
    if (!start_caret) begin
      case (ph_eff)
        PhRange: begin
          do_mark = 1'b1;
          for (int k = 0; k < SetBits; k++) begin
            mask[k] = (8'(k) >= prev_q) && (8'(k) <= c);
          end
        end
        PhEsc: begin
          do_mark = 1'b1;
          mask    = SetBits'(1) << mark_code;
        end
        default: begin
          do_mark = !((c == DashCode && !in_data_i.is_last &&
                       prev_vld_q && phase_q != PhStart) ||
                      (c == BackslashCode && !in_data_i.is_last));
          mask    = SetBits'(1) << mark_code;
        end
      endcase
    end
  end

  // Set update: a class start reloads the set, then members are set or cleared.
  // The polarity of a marked byte is that of the class in progress; a class
  // that starts without a caret is never negated.
  always_comb begin
    if (phase_q == PhStart) begin
      base_set = start_caret ? '1 : '0;
    end else begin
      base_set = set_q;
    end
    set_d = set_q;
    if (in_fire) begin
      if (in_data_i.is_empty) begin
        set_d = '0;
      end else if (!do_mark) begin
        set_d = base_set;
      end else if (neg_q) begin
        set_d = base_set & ~mask;
      end else begin
        set_d = base_set | mask;
      end
    end
  end

  // Output buffer: load on an ending byte, step through the words on each beat.
  always_comb begin
    snap_d = snap_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (out_fire) begin
      cnt_d = cnt_q + WordIdxW'(1);
      if (drain_done) begin
        busy_d = 1'b0;
      end
    end
    if (in_fire && finish) begin
      snap_d = set_d;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q      <= '0;
      prev_q     <= 8'd0;
      prev_vld_q <= 1'b0;
      neg_q      <= 1'b0;
      phase_q    <= PhStart;
      cnt_q      <= '0;
      busy_q     <= 1'b0;
    end else begin
      set_q      <= set_d;
      prev_q     <= prev_d;
      prev_vld_q <= prev_vld_d;
      neg_q      <= neg_d;
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      busy_q     <= busy_d;
    end
  end

  // Buffer payload needs no reset.
  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  // Output beat.
  assign out_valid_o           = busy_q;
  assign out_data_o.word_index = cnt_q;
  assign out_data_o.word_value = snap_q[WordBits*cnt_q +: WordBits];
  assign out_data_o.last_word  = (cnt_q == WordIdxW'(WordCount - 1));

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character class bitmap builder testbench
// Feeds class text byte by byte over the input channel and checks every
// 64-bit word of the finished set against a behavioral predictor. A short
// table of directed beats comes first, then random classes in four
// throttling phases, with one long output hold-off to fill the block.
// ----------------------------------------------------------------------------
module testbench;
  import ccbb_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned HoldCycles   = 160;
  localparam int unsigned PhaseBeats   = 62;
  localparam int unsigned DirRows      = 25;
  localparam int unsigned SettleCycles = 16;

  // Escape letters and the control codes they stand for, byte for byte.
  localparam logic [63:0] EscLetters = "abefnrtv";
  localparam logic [63:0] CtrlCodes  = {8'd7, 8'd8, 8'd27, 8'd12, 8'd10, 8'd13, 8'd9, 8'd11};

  // Lowest printable code; random text is mostly printable.
  localparam logic [7:0] PrintLo = 8'd32;
  localparam logic [7:0] PrintHi = 8'd126;

  typedef struct packed {
    ccbb_in_t     beat;
    logic         typed;
    logic [255:0] set;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  ccbb_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  ccbb_out_t out_data_o;

  // Predictor state of the class being parsed.
  logic [3:0][63:0] cls_bits;
  logic [7:0]       cls_prev;
  logic             cls_prev_ok;
  ccbb_phase_e      cls_phase;
  logic             cls_neg;

  ccbb_out_t   pending_words[$];
  dir_row_t    dir_rows[0:DirRows-1];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned phase_beats;
  int unsigned hold_left;
  bit          hold_req;

  char_class_bitmap_builder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock with a 20 ns period.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Reset is asserted at the start and then released.
  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Marks or clears one code depending on whether the class is negated.
  function automatic void mark_code(logic [7:0] code);
    cls_bits[code[7:6]][code[5:0]] = !cls_neg;
  endfunction

  // Folds one input beat into the predicted set. Returns 1 when the beat
  // finishes a class, with the finished set in done_set.
  function automatic bit fold_class_byte(ccbb_in_t b, output logic [255:0] done_set);
    logic [7:0] c;
    logic [7:0] m;
    bit         done;
    c    = b.char_code;
    m    = c;
    done = b.is_empty || b.is_last;
    if (b.is_empty) begin
      cls_bits = '0;
    end else if (cls_phase == PhStart && c == CaretCode) begin
      cls_neg     = 1'b1;
      cls_bits    = '1;
      cls_prev_ok = 1'b0;
      cls_phase   = PhIn;
    end else begin
      if (cls_phase == PhStart) begin
        cls_neg     = 1'b0;
        cls_bits    = '0;
        cls_prev_ok = 1'b0;
        cls_phase   = PhIn;
      end
      if (cls_phase == PhRange) begin
        // A reversed range marks nothing.
        for (int k = int'(cls_prev); k <= int'(c); k++) mark_code(k[7:0]);
        cls_prev_ok = 1'b0;
        cls_phase   = PhIn;
      end else if (cls_phase == PhEsc) begin
        for (int i = 0; i < 8; i++) begin
          if (EscLetters[8*i +: 8] == c) m = CtrlCodes[8*i +: 8];
        end
        mark_code(m);
        cls_prev    = m;
        cls_prev_ok = 1'b1;
        cls_phase   = PhIn;
      end else if (c == DashCode && !b.is_last && cls_prev_ok) begin
        cls_phase = PhRange;
      end else if (c == BackslashCode && !b.is_last) begin
        cls_phase = PhEsc;
      end else begin
        mark_code(c);
        cls_prev    = c;
        cls_prev_ok = 1'b1;
      end
    end
    done_set = cls_bits;
    if (done) begin
      cls_phase   = PhStart;
      cls_neg     = 1'b0;
      cls_prev    = '0;
      cls_prev_ok = 1'b0;
    end
    return done;
  endfunction

  // Queues the four words of a finished set, lowest codes first.
  function automatic void push_set_words(logic [255:0] set);
    ccbb_out_t w;
    for (int k = 0; k < WordCount; k++) begin
      w.word_index = k[WordIdxW-1:0];
      w.word_value = set[64*k +: 64];
      w.last_word  = (k == WordCount - 1);
      pending_words.push_back(w);
    end
  endfunction

  function automatic dir_row_t dir_row(logic [7:0] code, logic last, logic empty,
                                       logic typed, logic [255:0] set);
    dir_row_t r;
    r.beat.char_code = code;
    r.beat.is_last   = last;
    r.beat.is_empty  = empty;
    r.typed          = typed;
    r.set            = set;
    return r;
  endfunction

  // Random text byte, weighted toward dashes, backslashes and escapes.
  function automatic logic [7:0] random_text_byte();
    logic [7:0] r;
    case ($urandom_range(9))
      0:       r = DashCode;
      1:       r = BackslashCode;
      2:       r = EscLetters[8*$urandom_range(7) +: 8];
      3, 4:    r = 8'($urandom_range(255));
      default: r = 8'($urandom_range(PrintHi, PrintLo));
    endcase
    return r;
  endfunction

  // Offers one beat after a random gap, then predicts on acceptance.
  task automatic send_beat(ccbb_in_t b, logic typed, logic [255:0] typed_set);
    logic [255:0] set;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    phase_beats++;
    if (fold_class_byte(b, set)) push_set_words(typed ? typed_set : set);
  endtask

  // One class of random content; now and then it is cut short by an
  // empty beat instead of ending on its last byte.
  task automatic send_random_class();
    ccbb_in_t b;
    int       len;
    int       cut;
    len = $urandom_range(8, 1);
    cut = ($urandom_range(9) == 0) ? $urandom_range(len - 1, 0) : len;
    for (int i = 0; i < cut; i++) begin
      b.char_code = (i == 0 && $urandom_range(3) == 0) ? CaretCode : random_text_byte();
      b.is_last   = (i == len - 1);
      b.is_empty  = 1'b0;
      send_beat(b, 1'b0, '0);
    end
    if (cut < len) begin
      b.char_code = 8'($urandom);
      b.is_last   = 1'($urandom);
      b.is_empty  = 1'b1;
      send_beat(b, 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // Output side: checks each accepted word and throttles ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_words.size() == 0) begin
          $display("%0t: word with no set pending, actual %p", $time, out_data_o);
          mismatches++;
        end else begin
          if (out_data_o.word_index !== pending_words[0].word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $time,
                     pending_words[0].word_index, out_data_o.word_index);
            mismatches++;
          end
          if (out_data_o.word_value !== pending_words[0].word_value) begin
            $display("%0t: word_value expected %h actual %h", $time,
                     pending_words[0].word_value, out_data_o.word_value);
            mismatches++;
          end
          if (out_data_o.last_word !== pending_words[0].last_word) begin
            $display("%0t: last_word expected %0b actual %0b", $time,
                     pending_words[0].last_word, out_data_o.last_word);
            mismatches++;
          end
          void'(pending_words.pop_front());
        end
      end
      // A requested hold-off keeps ready low for a long stretch.
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Stimulus: directed table, then random classes in four phases.
  initial begin
    int unsigned phase_idle[4];
    int unsigned phase_stall[4];
    ccbb_in_t    noise;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    mismatches  = 0;
    cycle_count = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_req    = 1'b0;
    cls_bits    = '0;
    cls_prev    = '0;
    cls_prev_ok = 1'b0;
    cls_phase   = PhStart;
    cls_neg     = 1'b0;
    phase_idle  = '{0, 85, 0, 31};
    phase_stall = '{0, 0, 85, 31};

    // Empty class right after reset, lone caret, byte extremes, trailing
    // dash and backslash.
    dir_rows[0]  = dir_row(8'hFF, 1'b1, 1'b1, 1'b1, '0);
    dir_rows[1]  = dir_row(CaretCode, 1'b1, 1'b0, 1'b1, '1);
    dir_rows[2]  = dir_row(8'h00, 1'b1, 1'b0, 1'b1, 256'd1);
    dir_rows[3]  = dir_row(8'hFF, 1'b1, 1'b0, 1'b1, 256'd1 << 255);
    dir_rows[4]  = dir_row(DashCode, 1'b1, 1'b0, 1'b1, 256'd1 << DashCode);
    dir_rows[5]  = dir_row(BackslashCode, 1'b1, 1'b0, 1'b1, 256'd1 << BackslashCode);
    // Plain range, then a reversed one.
    dir_rows[6]  = dir_row("a", 1'b0, 1'b0, 1'b0, '0);
    dir_rows[7]  = dir_row(DashCode, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[8]  = dir_row("z", 1'b1, 1'b0, 1'b0, '0);
    dir_rows[9]  = dir_row("z", 1'b0, 1'b0, 1'b0, '0);
    dir_rows[10] = dir_row(DashCode, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[11] = dir_row("a", 1'b1, 1'b0, 1'b0, '0);
    // Escaped newline.
    dir_rows[12] = dir_row(BackslashCode, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[13] = dir_row("n", 1'b1, 1'b0, 1'b0, '0);
    // Negated class with a dash that follows no member.
    dir_rows[14] = dir_row(CaretCode, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[15] = dir_row(DashCode, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[16] = dir_row("x", 1'b1, 1'b0, 1'b0, '0);
    // A backslash as range end is taken as is.
    dir_rows[17] = dir_row("0", 1'b0, 1'b0, 1'b0, '0);
    dir_rows[18] = dir_row(DashCode, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[19] = dir_row(BackslashCode, 1'b1, 1'b0, 1'b0, '0);
    // An empty beat drops the class in progress.
    dir_rows[20] = dir_row("q", 1'b0, 1'b0, 1'b0, '0);
    dir_rows[21] = dir_row(8'hFF, 1'b1, 1'b1, 1'b1, '0);
    // Full range covers every code.
    dir_rows[22] = dir_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[23] = dir_row(DashCode, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[24] = dir_row(8'hFF, 1'b1, 1'b0, 1'b1, '1);

    do @(posedge clk_i); while (!rst_ni);

    for (int r = 0; r < DirRows; r++) begin
      send_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].set);
    end
    in_valid_i <= 1'b0;
    wait_drained();

    // Random classes; the first phase opens with a long output hold-off
    // so the block fills up and stalls its input.
    for (int p = 0; p < 4; p++) begin
      idle_pct    = phase_idle[p];
      stall_pct   = phase_stall[p];
      phase_beats = 0;
      if (p == 0) hold_req = 1'b1;
      while (phase_beats < PhaseBeats) begin
        if ($urandom_range(9) == 0) begin
          noise.char_code = 8'($urandom);
          noise.is_last   = 1'($urandom);
          noise.is_empty  = 1'($urandom);
          send_beat(noise, 1'b0, '0);
        end else begin
          send_random_class();
        end
      end
      in_valid_i <= 1'b0;
      wait_drained();
    end

    // Let any stray words show up before closing.
    stall_pct = 0;
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
